// ===== rtl/ssft_pkg.sv =====
// shared types and register indexes for the source scan flow tracker
// no dependencies

package ssft_pkg;

  localparam logic [1:0] REG_BLACK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FLUSH_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_FIRST_FLUSH     = 2'd2;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [39:0] ppp;
  } pkt_t;

  typedef struct packed {
    logic flush;
    logic look;
    logic upd;
    logic known;
  } ctl_t;

  typedef struct packed {
    logic        black;
    logic        repeat_hit;
    logic [4:0]  single_flows;
    logic [15:0] run;
  } res_t;

endpackage

// ===== rtl/ssft_cell.sv =====
// one source entry: address, lru rank, counters and its single-packet flow list
// depends on ssft_pkg

module ssft_cell #(
  parameter int SOURCES = 128,
  parameter int FLOWS   = 16,
  parameter int INDEX   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssft_pkg::pkt_t             pkt,
  input  ssft_pkg::ctl_t             ctl,
  input  logic [$clog2(SOURCES)-1:0] target,
  input  logic [$clog2(SOURCES)-1:0] front_rank,
  input  logic [4:0]                 thr,
  output logic                       hit,
  output logic                       sel_now,
  output logic [$clog2(SOURCES)-1:0] rank,
  output ssft_pkg::res_t             res
);
  import ssft_pkg::*;

  localparam int RW = $clog2(SOURCES);
  localparam int PW = $clog2(FLOWS);
  localparam int CW = $clog2(FLOWS + 1);

  logic          valid;
  logic [31:0]   addr;
  logic          black;
  logic [CW-1:0] cnt;
  logic [15:0]   run;
  logic          rep;
  logic          sel;
  logic          fv  [FLOWS];
  logic [31:0]   fd  [FLOWS];
  logic [39:0]   fp  [FLOWS];
  logic [PW-1:0] pos [FLOWS];

  logic          m;
  logic [PW-1:0] mi;
  logic [PW-1:0] wpos;
  logic [PW-1:0] w;
  logic          full;
  logic [PW-1:0] mv;
  logic          do_move;
  logic [PW-1:0] p_mv;
  logic [CW-1:0] cnt_next;
  logic [15:0]   run_next;
  logic          black_next;

  assign hit     = valid && (addr == pkt.src);
  assign sel_now = hit || (!ctl.known && (rank == target));
  assign full    = (cnt == CW'(FLOWS));

  always_comb begin
    m  = 1'b0;
    mi = '0;
    for (int k = 0; k < FLOWS; k++) begin
      if (fv[k] && fd[k] == pkt.dst && fp[k] == pkt.ppp) begin
        m  = 1'b1;
        mi = PW'(k);
      end
    end
  end

  always_comb begin
    wpos = (ctl.known && !m && !full) ? PW'(cnt) : '0;
    w    = '0;
    for (int k = FLOWS - 1; k >= 0; k--) begin
      if (pos[k] == wpos) w = PW'(k);
    end
  end

  assign mv      = m ? mi : w;
  assign do_move = ctl.known && (m || full);
  assign p_mv    = pos[mv];

  always_comb begin
    if (!ctl.known) begin
      cnt_next = CW'(1);
      run_next = 16'd1;
    end else if (m) begin
      cnt_next = (cnt != '0) ? cnt - CW'(1) : cnt;
      run_next = '0;
    end else begin
      cnt_next = full ? cnt : cnt + CW'(1);
      run_next = (run != 16'hFFFF) ? run + 16'd1 : run;
    end
    black_next = (ctl.known && black) || (8'(cnt_next) >= 8'(thr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= RW'(INDEX);
      sel   <= 1'b0;
      for (int k = 0; k < FLOWS; k++) pos[k] <= PW'(k);
    end else begin
      if (ctl.flush) valid <= 1'b0;
      if (ctl.look) sel <= sel_now;
      if (ctl.upd) begin
        if (sel) begin
          rank <= '0;
        end else if (rank < front_rank) begin
          rank <= rank + RW'(1);
        end
        if (sel) begin
          black <= black_next;
          cnt   <= cnt_next;
          run   <= run_next;
          rep   <= ctl.known && m;
          if (!ctl.known) begin
            valid <= 1'b1;
            addr  <= pkt.src;
          end
          for (int k = 0; k < FLOWS; k++) begin
            if (!ctl.known) begin
              fv[k] <= (PW'(k) == w);
            end else if (m && PW'(k) == mi) begin
              fv[k] <= 1'b0;
            end else if (!m && PW'(k) == w) begin
              fv[k] <= 1'b1;
            end
            if ((!ctl.known || !m) && PW'(k) == w) begin
              fd[k] <= pkt.dst;
              fp[k] <= pkt.ppp;
            end
            if (do_move) begin
              if (PW'(k) == mv) begin
                pos[k] <= PW'(FLOWS - 1);
              end else if (pos[k] > p_mv) begin
                pos[k] <= pos[k] - PW'(1);
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (sel) begin
      res.black        = black;
      res.repeat_hit   = rep;
      res.single_flows = 5'(cnt);
      res.run          = run;
    end
  end

endmodule

// ===== rtl/source_scan_flow_tracker_unit.sv =====
// top level of the source scan flow tracker: sequencer, registers and the row of cells
// depends on ssft_pkg and ssft_cell

// A packet is taken when start is high and busy is low. Its result shows on the
// output ports with done high for one cycle, once the four steps are through;
// start may be raised again in that same cycle, as busy is then low, so a new
// packet is taken only after the last one's result. The four steps are the
// flush check, the parallel address compare of all cells, the rank and flow
// list update in the cells, and the collection of the chosen cell's counters.
// The receiver cannot stall; a result not taken in its cycle is gone.
module source_scan_flow_tracker_unit #(
  parameter int SOURCES          = 128,
  parameter int FLOWS_PER_SOURCE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] arrival_time,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output logic        source_black,
  output logic        source_known,
  output logic        flow_repeat,
  output logic        source_evicted,
  output logic        table_flushed,
  output logic [4:0]  single_flows,
  output logic [15:0] new_flow_run
);
  import ssft_pkg::*;

  localparam int RW = $clog2(SOURCES);
  localparam int IW = $clog2(SOURCES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_UPD  = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t        state;
  logic [4:0]    thr;
  logic [31:0]   interval;
  logic [31:0]   nft;
  logic          started;
  logic [IW-1:0] in_use;
  pkt_t          pkt;
  logic          known;
  logic [RW-1:0] front_rank;

  logic          start_acc;
  logic          flush_now;
  ctl_t          ctl;
  logic [RW-1:0] target;
  logic          hit_any;
  logic [RW-1:0] sel_rank;
  res_t          res_all;

  logic          hit     [SOURCES];
  logic          sel_now [SOURCES];
  logic [RW-1:0] rank    [SOURCES];
  res_t          res     [SOURCES];

  assign busy      = (state != S_IDLE);
  assign start_acc = start && (state == S_IDLE);
  assign flush_now = start_acc && (nft < arrival_time);
  assign target    = (in_use == IW'(SOURCES)) ? RW'(SOURCES - 1) : in_use[RW-1:0];

  always_comb begin
    ctl.flush = flush_now;
    ctl.look  = (state == S_LOOK);
    ctl.upd   = (state == S_UPD);
    ctl.known = (state == S_LOOK) ? hit_any : known;
  end

  always_comb begin
    hit_any  = 1'b0;
    sel_rank = '0;
    res_all  = '0;
    for (int i = 0; i < SOURCES; i++) begin
      hit_any  = hit_any | hit[i];
      sel_rank = sel_rank | (sel_now[i] ? rank[i] : '0);
      res_all  = res_all | res[i];
    end
  end

  for (genvar g = 0; g < SOURCES; g++) begin : g_cell
    ssft_cell #(
      .SOURCES (SOURCES),
      .FLOWS   (FLOWS_PER_SOURCE),
      .INDEX   (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .pkt        (pkt),
      .ctl        (ctl),
      .target     (target),
      .front_rank (front_rank),
      .thr        (thr),
      .hit        (hit[g]),
      .sel_now    (sel_now[g]),
      .rank       (rank[g]),
      .res        (res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      thr         <= 5'd8;
      interval    <= 32'd1000;
      nft         <= 32'd1000;
      started     <= 1'b0;
      in_use      <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_BLACK_THRESHOLD: thr <= wr_data[4:0];
          REG_FLUSH_INTERVAL:  interval <= wr_data;
          REG_FIRST_FLUSH: begin
            if (!started) nft <= wr_data;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start_acc) begin
            pkt.src       <= src_addr;
            pkt.dst       <= dst_addr;
            pkt.ppp       <= {src_port, dst_port, protocol};
            started       <= 1'b1;
            table_flushed <= flush_now;
            if (flush_now) begin
              nft    <= nft + interval;
              in_use <= '0;
            end
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          known          <= hit_any;
          front_rank     <= sel_rank;
          source_evicted <= !hit_any && (in_use == IW'(SOURCES));
          if (!hit_any && in_use != IW'(SOURCES)) in_use <= in_use + IW'(1);
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_RES;
        end
        S_RES: begin
          source_black <= res_all.black;
          source_known <= known;
          flow_repeat  <= res_all.repeat_hit;
          single_flows <= res_all.single_flows;
          new_flow_run <= res_all.run;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ssft_chk.sv =====
// port-level checks for the source scan flow tracker, bound to the top level
// depends on source_scan_flow_tracker_unit

module ssft_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        source_known,
  input logic        flow_repeat,
  input logic        source_evicted,
  input logic [4:0]  single_flows,
  input logic [15:0] new_flow_run
);

  a_beat_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done) else $error("result beat not on time");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  a_new_source: assert property (@(posedge clk) disable iff (rst)
    done && !source_known |-> single_flows == 5'd1 && new_flow_run == 16'd1 && !flow_repeat)
    else $error("new source counters wrong");

  a_evict_new: assert property (@(posedge clk) disable iff (rst)
    done && source_evicted |-> !source_known) else $error("eviction on known source");

endmodule

bind source_scan_flow_tracker_unit ssft_chk u_ssft_chk (.*);
